// ----- rtl/dqms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqms_pkg: shared types and constants for the deque core
// Holds the store geometry, command and result codes, the controller state
// type, the control and status structs, and the ring index helper.
// ----------------------------------------------------------------------------
package dqms_pkg;

	// Store geometry.
	localparam int CAPACITY = 32;
	localparam int KEY_W    = 32;
	localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = CNT_W + 1;
	localparam int CMD_W    = 2;
	localparam int KIND_W   = 2;
	localparam int POS_W    = 6;

	// Command codes on the input channel.
	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SWAP_DUMP = 2'd2;

	// Result kinds on the output channel.
	localparam logic [KIND_W-1:0] KIND_KEY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NULL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FULL = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SW_RD_A,
		ST_SW_RD_B,
		ST_SW_WR_A,
		ST_SW_WR_B,
		ST_DUMP_PRIME,
		ST_DUMP
	} state_t;

	// Read address selection for the key memory.
	typedef enum logic [1:0] {
		RD_SLOT_A,
		RD_SLOT_B,
		RD_DUMP_FIRST,
		RD_DUMP_NEXT
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              ins_front;
		logic              ins_tail;
		logic              load_out;
		logic [KIND_W-1:0] out_kind;
		logic              latch_swap;
		rd_sel_t           rd_sel;
		logic              cap_tmp;
		logic              wr_a;
		logic              wr_b;
		logic              dump_init;
		logic              dump_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic swap_ok;
		logic out_free;
		logic dump_last;
	} dp_stat_t;

	// Ring slot of the key at a given offset from the front.
	function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(off);
		if (s >= SUM_W'(CAPACITY)) begin
			s = s - SUM_W'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/dqms_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqms_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dqms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                 wr_data,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and registered read port returning the old data on a clash.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ----- rtl/dqms_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqms_ctrl: command sequencer for the deque core
// Accepts commands, steps a swap through its reads and writes of the key memory and
// paces the reversed dump against the result channel.
// ----------------------------------------------------------------------------
module dqms_ctrl import dqms_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	input  wire logic [CMD_W-1:0] command,
	input  wire dp_stat_t         stat,
	output logic                  cmd_stall,
	output ctl_cmd_t              ctl
);

	state_t state_q;
	state_t state_d;
	logic   needs_out;
	logic   accept;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A command that answers at once waits until the result register is free.
	always_comb begin
		needs_out = ((command == CMD_INS_FRONT || command == CMD_INS_TAIL) && stat.full)
			|| (command == CMD_SWAP_DUMP && !stat.swap_ok);
		cmd_stall = (state_q != ST_IDLE) || (needs_out && !stat.out_free);
		accept    = cmd_valid && !cmd_stall;
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		ctl.rd_sel = RD_SLOT_A;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (command) inside
						CMD_INS_FRONT, CMD_INS_TAIL: begin
							if (stat.full) begin
								ctl.load_out = 1'b1;
								ctl.out_kind = KIND_FULL;
							end else begin
								ctl.ins_front = (command == CMD_INS_FRONT);
								ctl.ins_tail  = (command == CMD_INS_TAIL);
							end
						end
						CMD_SWAP_DUMP: begin
							if (stat.swap_ok) begin
								ctl.latch_swap = 1'b1;
								state_d = ST_SW_RD_A;
							end else begin
								ctl.load_out = 1'b1;
								ctl.out_kind = KIND_NULL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SW_RD_A: begin
				ctl.rd_sel = RD_SLOT_A;
				state_d = ST_SW_RD_B;
			end
			ST_SW_RD_B: begin
				ctl.rd_sel  = RD_SLOT_B;
				ctl.cap_tmp = 1'b1;
				state_d = ST_SW_WR_A;
			end
			ST_SW_WR_A: begin
				ctl.wr_a = 1'b1;
				state_d = ST_SW_WR_B;
			end
			ST_SW_WR_B: begin
				ctl.wr_b = 1'b1;
				state_d = ST_DUMP_PRIME;
			end
			ST_DUMP_PRIME: begin
				ctl.rd_sel    = RD_DUMP_FIRST;
				ctl.dump_init = 1'b1;
				state_d = ST_DUMP;
			end
			ST_DUMP: begin
				ctl.rd_sel    = RD_DUMP_NEXT;
				ctl.dump_load = stat.out_free;
				if (stat.out_free && stat.dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/dqms_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqms_dpath: ring buffer datapath for the deque core
// Holds the front index and entry count, the key memory, the swap slots and
// the result register.
// ----------------------------------------------------------------------------
module dqms_dpath import dqms_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic signed [KEY_W-1:0] value,
	input  wire logic [POS_W-1:0]        front_pos,
	input  wire logic [POS_W-1:0]        back_pos,
	input  wire ctl_cmd_t                ctl,
	input  wire logic                    res_stall,
	output dp_stat_t                     stat,
	output logic                         res_valid,
	output logic [KIND_W-1:0]            kind,
	output logic signed [KEY_W-1:0]      key_out,
	output logic                         last
);

	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] slot_a_q;
	logic [IDX_W-1:0] slot_b_q;
	logic [KEY_W-1:0] tmp_q;
	logic [CNT_W-1:0] dump_off_q;
	logic             out_valid_q;

	logic [IDX_W-1:0] front_dec;
	logic [POS_W-1:0] count_w;
	logic [CNT_W-1:0] next_off;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [KEY_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [KEY_W-1:0] mem_rdata;

	// Status towards the controller.
	always_comb begin
		count_w        = POS_W'(count_q);
		stat.full      = (count_q >= CNT_W'(CAPACITY));
		stat.swap_ok   = (count_q != '0)
			&& (front_pos != '0) && (front_pos <= count_w)
			&& (back_pos != '0) && (back_pos <= count_w);
		stat.out_free  = !out_valid_q || !res_stall;
		stat.dump_last = (dump_off_q == '0);
	end

	// Front index step for an insert at the front.
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;

	// Front index and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else begin
			if (ctl.ins_front) begin
				front_q <= front_dec;
			end
			if (ctl.ins_front || ctl.ins_tail) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Swap slots, the first swapped key and the dump offset.
	always_ff @(posedge clk) begin
		if (ctl.latch_swap) begin
			slot_a_q <= ring_slot(front_q, CNT_W'(front_pos - 1'b1));
			slot_b_q <= ring_slot(front_q, CNT_W'(count_w - back_pos));
		end
		if (ctl.cap_tmp) begin
			tmp_q <= mem_rdata;
		end
		if (ctl.dump_init) begin
			dump_off_q <= count_q - 1'b1;
		end else if (ctl.dump_load && !stat.dump_last) begin
			dump_off_q <= dump_off_q - 1'b1;
		end
	end

	// Memory write port: inserts and the two halves of a swap.
	always_comb begin
		mem_we    = ctl.ins_front || ctl.ins_tail || ctl.wr_a || ctl.wr_b;
		mem_waddr = slot_b_q;
		mem_wdata = tmp_q;
		if (ctl.ins_front) begin
			mem_waddr = front_dec;
			mem_wdata = value;
		end else if (ctl.ins_tail) begin
			mem_waddr = ring_slot(front_q, count_q);
			mem_wdata = value;
		end else if (ctl.wr_a) begin
			mem_waddr = slot_a_q;
			mem_wdata = mem_rdata;
		end
	end

	// Memory read port; during the dump the address holds while the result stalls.
	always_comb begin
		next_off = (ctl.dump_load && !stat.dump_last) ? dump_off_q - 1'b1 : dump_off_q;
		unique case (ctl.rd_sel)
			RD_SLOT_A:     mem_raddr = slot_a_q;
			RD_SLOT_B:     mem_raddr = slot_b_q;
			RD_DUMP_FIRST: mem_raddr = ring_slot(front_q, count_q - 1'b1);
			RD_DUMP_NEXT:  mem_raddr = ring_slot(front_q, next_off);
			default:       mem_raddr = slot_a_q;
		endcase
	end

	dqms_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out || ctl.dump_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (ctl.dump_load) begin
			kind    <= KIND_KEY;
			key_out <= mem_rdata;
			last    <= stat.dump_last;
		end else if (ctl.load_out) begin
			kind    <= ctl.out_kind;
			key_out <= '0;
			last    <= 1'b1;
		end
	end

	assign res_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/deque_with_mirror_swap_dump_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_mirror_swap_dump_core: bounded double-ended queue of keys
// Ring buffer of signed keys with insert at either end, and a swap of two
// mirrored positions followed by a dump of all keys from tail to head.
//
//   Channel  Handshake               Payload
//   cmd      cmd_valid / cmd_stall   command, value, front_pos, back_pos
//   res      res_valid / res_stall   kind, key_out, last
//
// An insert writes its key when accepted; a full or null answer loads one result beat.
// A valid swap reads both slots, writes them back crossed and primes the dump;
// the dump then sends one key per cycle while the result is not stalled. The
// single read and single write port of the key RAM set these steps.
// Reset clears the front index, the entry count and the result valid flag;
// the key RAM is not cleared. A stalled result beat holds the dump in place.
// ----------------------------------------------------------------------------
module deque_with_mirror_swap_dump_core import dqms_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cmd_valid,
	output logic                         cmd_stall,
	input  wire logic [CMD_W-1:0]        command,
	input  wire logic signed [KEY_W-1:0] value,
	input  wire logic [POS_W-1:0]        front_pos,
	input  wire logic [POS_W-1:0]        back_pos,
	output logic                         res_valid,
	input  wire logic                    res_stall,
	output logic [KIND_W-1:0]            kind,
	output logic signed [KEY_W-1:0]      key_out,
	output logic                         last
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// Controller.
	dqms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.command  (command),
		.stat     (stat),
		.cmd_stall(cmd_stall),
		.ctl      (ctl)
	);

	// Datapath.
	dqms_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (value),
		.front_pos(front_pos),
		.back_pos (back_pos),
		.ctl      (ctl),
		.res_stall(res_stall),
		.stat     (stat),
		.res_valid(res_valid),
		.kind     (kind),
		.key_out  (key_out),
		.last     (last)
	);

	// A new result is never loaded over a stalled beat.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !(ctl.load_out || ctl.dump_load))
		else $error("result register loaded while its beat was stalled");

	// An insert is never written into a full store.
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.ins_front || ctl.ins_tail) |-> !stat.full)
		else $error("insert stored into a full ring");

	// The swap writes and the dump loads happen only while new commands are held off.
	a_swap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_a || ctl.wr_b || ctl.dump_load) |-> cmd_stall)
		else $error("swap or dump activity while commands were accepted");

	// The dump starts in the cycle after the second swap write.
	a_dump_follows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_b |=> ctl.dump_init)
		else $error("dump did not follow the swap");

endmodule
`default_nettype wire

// ----- verif/tb_deque_with_mirror_swap_dump_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deque_with_mirror_swap_dump_core: self-checking bench for the deque core
// Sends inserts at both ends, swap-and-dump commands with valid and invalid
// positions, and unused command codes, with random gaps on the command side
// and random stalls on the result side. A shadow ring of keys predicts every
// result beat, and each arriving beat is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_deque_with_mirror_swap_dump_core import dqms_pkg::*; ();

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 410;
	localparam int DRAIN_EVERY  = 60;
	localparam int TAIL_CYCLES  = CAPACITY + 10;
	localparam longint CYCLE_LIMIT = 1_000_000;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic signed [KEY_W-1:0] val;
		logic [POS_W-1:0]        fpos;
		logic [POS_W-1:0]        bpos;
		bit                      drain;
	} cmd_beat_t;

	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic signed [KEY_W-1:0] key;
		logic                    last;
	} res_beat_t;

	// Clock, reset and the ports of the block.
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cmd_valid = 1'b0;
	logic                    cmd_stall;
	logic [CMD_W-1:0]        command = '0;
	logic signed [KEY_W-1:0] value = '0;
	logic [POS_W-1:0]        front_pos = '0;
	logic [POS_W-1:0]        back_pos = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [KIND_W-1:0]       kind;
	logic signed [KEY_W-1:0] key_out;
	logic                    last;

	// Shadow ring of keys and the result beats still to arrive.
	logic signed [KEY_W-1:0] mirror_keys [CAPACITY];
	int unsigned             mirror_front = 0;
	int unsigned             mirror_count = 0;
	res_beat_t               due_results[$];

	// Command beats waiting to be sent, and the occupancy they will build up.
	cmd_beat_t cmd_plan[$];
	int        plan_held = 0;

	// Driver and monitor bookkeeping.
	cmd_beat_t cur_beat;
	bit        drv_busy = 1'b0;
	bit        drv_burst = 1'b0;
	int        drv_gap = 0;
	int        beats_due = 0;
	int        beats_seen = 0;
	int        items_sent = 0;
	bit        mon_burst = 1'b0;
	int        mon_stall = 0;
	res_beat_t mon_want;
	int        seen_keys = 0;
	int        seen_nulls = 0;
	int        seen_fulls = 0;
	int        mismatches = 0;
	longint    cycle_count = 0;

	deque_with_mirror_swap_dump_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command),
		.value     (value),
		.front_pos (front_pos),
		.back_pos  (back_pos),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.key_out   (key_out),
		.last      (last)
	);

	initial forever #5 clk = ~clk;

	function automatic int unsigned mirror_slot(int unsigned off);
		return (mirror_front + off) % CAPACITY;
	endfunction

	function automatic void expect_beat(logic [KIND_W-1:0] k, logic signed [KEY_W-1:0] key,
			logic lst);
		res_beat_t r;
		r.kind = k;
		r.key  = key;
		r.last = lst;
		due_results.push_back(r);
	endfunction

	// Apply one accepted command to the shadow ring and queue the beats it causes.
	function automatic int model_command(cmd_beat_t b);
		int unsigned sa;
		int unsigned sb;
		logic signed [KEY_W-1:0] t;
		int n;
		n = 0;
		case (b.cmd) inside
			CMD_INS_FRONT, CMD_INS_TAIL: begin
				if (mirror_count >= CAPACITY) begin
					expect_beat(KIND_FULL, '0, 1'b1);
					n = 1;
				end else if (b.cmd == CMD_INS_FRONT) begin
					mirror_front = (mirror_front + CAPACITY - 1) % CAPACITY;
					mirror_keys[mirror_front] = b.val;
					mirror_count++;
				end else begin
					mirror_keys[mirror_slot(mirror_count)] = b.val;
					mirror_count++;
				end
			end
			CMD_SWAP_DUMP: begin
				if (b.fpos < 1 || b.fpos > mirror_count || b.bpos < 1 ||
						b.bpos > mirror_count) begin
					expect_beat(KIND_NULL, '0, 1'b1);
					n = 1;
				end else begin
					sa = mirror_slot(b.fpos - 1);
					sb = mirror_slot(mirror_count - b.bpos);
					t = mirror_keys[sa];
					mirror_keys[sa] = mirror_keys[sb];
					mirror_keys[sb] = t;
					// The dump runs from the tail back to the head.
					for (int i = mirror_count; i > 0; i--) begin
						expect_beat(KIND_KEY, mirror_keys[mirror_slot(i - 1)], i == 1);
					end
					n = mirror_count;
				end
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	// Wait length for the next beat; bursts with no waiting come and go at random.
	function automatic int pick_wait(inout bit burst);
		if ($urandom_range(0, 31) == 0) begin
			burst = !burst;
		end
		return burst ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic void plan(logic [CMD_W-1:0] c, logic signed [KEY_W-1:0] v, int fp,
			int bp, bit drain);
		cmd_beat_t b;
		b.cmd   = c;
		b.val   = v;
		b.fpos  = fp[POS_W-1:0];
		b.bpos  = bp[POS_W-1:0];
		b.drain = drain;
		cmd_plan.push_back(b);
		if ((c == CMD_INS_FRONT || c == CMD_INS_TAIL) && plan_held < CAPACITY) begin
			plan_held++;
		end
	endfunction

	// Command driver: one beat at a time from the plan, with random gaps.
	// A beat marked for draining is held back until every due result has come.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			drv_busy = 1'b0;
			drv_gap = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				beats_due += model_command(cur_beat);
				items_sent++;
				drv_busy = 1'b0;
				drv_gap = pick_wait(drv_burst);
			end
			if (!drv_busy) begin
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (cmd_plan.size() > 0 &&
						!(cmd_plan[0].drain && beats_seen != beats_due)) begin
					cur_beat = cmd_plan.pop_front();
					drv_busy = 1'b1;
					command   <= cur_beat.cmd;
					value     <= cur_beat.val;
					front_pos <= cur_beat.fpos;
					back_pos  <= cur_beat.bpos;
				end
			end
			cmd_valid <= drv_busy;
		end
	end

	// Result monitor: checks each accepted beat against the oldest expectation,
	// then stalls for a random number of cycles before taking the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			mon_stall = 0;
		end else begin
			if (res_valid && !res_stall) begin
				beats_seen <= beats_seen + 1;
				if (due_results.size() == 0) begin
					$error("Result beat with nothing expected: kind %0d, key_out %0d, last %0d",
						kind, key_out, last);
					mismatches++;
				end else begin
					mon_want = due_results.pop_front();
					if (kind !== mon_want.kind) begin
						$error("kind: expected %0d, actual %0d", mon_want.kind, kind);
						mismatches++;
					end
					if (key_out !== mon_want.key) begin
						$error("key_out: expected %0d, actual %0d", mon_want.key, key_out);
						mismatches++;
					end
					if (last !== mon_want.last) begin
						$error("last: expected %0d, actual %0d", mon_want.last, last);
						mismatches++;
					end
					case (mon_want.kind)
						KIND_KEY:  seen_keys++;
						KIND_NULL: seen_nulls++;
						default:   seen_fulls++;
					endcase
				end
				mon_stall = pick_wait(mon_burst);
			end
			if (mon_stall > 0) begin
				res_stall <= 1'b1;
				mon_stall--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d result beats outstanding.",
				cycle_count, due_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin
		int counted;
		int r;
		int fp;
		int bp;
		bit drain;
		logic signed [KEY_W-1:0] v;

		// Directed part: empty store, extreme keys, zero and too large positions, a key
		// swapped with itself, a ring that wraps below slot zero, unused code.
		plan(CMD_SWAP_DUMP, '0, 1, 1, 1'b0);
		plan(CMD_UNUSED, '0, 0, 0, 1'b0);
		plan(CMD_INS_FRONT, KEY_MIN, 0, 0, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 1, 1, 1'b0);
		plan(CMD_INS_TAIL, KEY_MAX, 0, 0, 1'b0);
		plan(CMD_INS_FRONT, '0, 0, 0, 1'b0);
		plan(CMD_INS_TAIL, -1, 0, 0, 1'b0);
		plan(CMD_INS_FRONT, 1, 0, 0, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 0, 1, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 1, 0, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 6, 1, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 1, 63, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 63, 63, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 1, 1, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 3, 3, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 2, 1, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 5, 5, 1'b0);
		plan(CMD_UNUSED, -1, 63, 63, 1'b0);
		plan(CMD_INS_TAIL, 32'sh5555_5555, 0, 0, 1'b0);
		plan(CMD_INS_FRONT, 32'shAAAA_AAAA, 42, 21, 1'b0);
		plan(CMD_SWAP_DUMP, '0, 7, 7, 1'b0);

		// Random part: mostly swaps that hit real positions, inserts that grow the
		// store until it is full and then bounce, some bad positions and noise.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			drain = (counted == 0) || (counted % DRAIN_EVERY == DRAIN_EVERY - 1);
			case ($urandom_range(0, 7))
				0: v = KEY_MIN;
				1: v = KEY_MAX;
				2: v = -1;
				default: v = $urandom;
			endcase
			r = $urandom_range(0, 99);
			if (r < 4) begin
				plan(CMD_UNUSED, v, $urandom_range(0, 63), $urandom_range(0, 63), 1'b0);
			end else begin
				if (r < 26) begin
					plan($urandom_range(0, 1) ? CMD_INS_TAIL : CMD_INS_FRONT, v, 0, 0, drain);
				end else if (r < 84 && plan_held > 0) begin
					fp = $urandom_range(1, plan_held);
					if ($urandom_range(0, 9) == 0) begin
						bp = plan_held - fp + 1;
					end else begin
						bp = $urandom_range(1, plan_held);
					end
					plan(CMD_SWAP_DUMP, v, fp, bp, drain);
				end else begin
					fp = $urandom_range(0, 63);
					bp = $urandom_range(0, 63);
					case ($urandom_range(0, 4))
						0: fp = 0;
						1: bp = 0;
						2: fp = (plan_held < 63) ? $urandom_range(plan_held + 1, 63) : 0;
						3: bp = (plan_held < 63) ? $urandom_range(plan_held + 1, 63) : 0;
						default: begin
						end
					endcase
					plan(CMD_SWAP_DUMP, v, fp, bp, drain);
				end
				counted++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_plan.size() != 0 || drv_busy || cmd_valid || beats_seen != beats_due) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (due_results.size() != 0) begin
			$error("%0d expected result beats never arrived", due_results.size());
			mismatches++;
		end

		$display("Covered %0d commands and %0d result beats: %0d keys, %0d null, %0d full.",
			items_sent, beats_seen, seen_keys, seen_nulls, seen_fulls);
		$display("The store finished with %0d keys, front at ring slot %0d; %0d mismatches.",
			mirror_count, mirror_front, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/dqms_pkg.sv
rtl/dqms_ram.sv
rtl/dqms_ctrl.sv
rtl/dqms_dpath.sv
rtl/deque_with_mirror_swap_dump_core.sv
verif/tb_deque_with_mirror_swap_dump_core.sv
